[rtl/core/pmst_pkg.sv]
package pmst_pkg;

  localparam int CMD_W = 2;
  localparam int VTX_W = 5;
  localparam int WGT_W = 17;
  localparam int TOT_W = 22;
  localparam int CNT_W = 6;

  // weight value that marks a missing edge
  localparam logic [WGT_W-1:0] NO_EDGE = 17'd99999;

  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd32;

  // request commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

  // result kinds
  localparam logic KIND_JOIN    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

[rtl/core/prim_mst_adjacency_matrix.sv]
// Prim minimum spanning tree engine over a stored adjacency matrix of up to
// MAX_VERTICES vertices. A request is taken when start is high and busy is
// low; results appear for one cycle each with out_valid and cannot be held
// off. After reset the block sweeps the whole matrix to "no edge", one entry
// per cycle, with busy high; a clear request runs the same sweep. An add
// request writes both mirrored entries, one after the other, on the single
// matrix write port. A run request emits the root the cycle after it is
// taken, then makes one pass over vertices 1..n-1 per joined vertex through
// a single relax-and-compare unit fed by the matrix read port; each pass
// ends in a join step that emits a result (a joined vertex or the summary).
// busy stays high through the last result.
module prim_mst_adjacency_matrix #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pmst_pkg::CMD_W-1:0]     in_command,
  input  logic [pmst_pkg::VTX_W-1:0]     in_vertex_a,
  input  logic [pmst_pkg::VTX_W-1:0]     in_vertex_b,
  input  logic [pmst_pkg::WGT_W-1:0]     in_edge_weight,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmst_pkg::CNT_W-1:0]     cfg_vertex_count,
  output logic                           out_valid,
  output logic                           out_kind,
  output logic [pmst_pkg::VTX_W-1:0]     out_joined_vertex,
  output logic [pmst_pkg::VTX_W-1:0]     out_parent_vertex,
  output logic [pmst_pkg::WGT_W-1:0]     out_joining_weight,
  output logic [pmst_pkg::TOT_W-1:0]     out_total_weight,
  output logic                           out_all_reached,
  output logic                           out_last
);
  import pmst_pkg::*;

  localparam int Depth = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(Depth);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic [AW-1:0] Stride   = AW'(MAX_VERTICES);
  localparam logic [NW-1:0] NMax     = NW'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD2,
    S_PASS,
    S_JOIN
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_addr_r;
  logic [AW-1:0]         add_addr_r;
  logic [WGT_W-1:0]      add_w_r;
  logic [CNT_W-1:0]      count_r;
  logic [NW-1:0]         n_r;
  logic [NW-1:0]         joined_r;
  logic [VW-1:0]         piv_r;
  logic [VW-1:0]         issue_j_r;
  logic                  iss_r;
  logic                  v1_r;
  logic [VW-1:0]         j1_r;
  logic                  init_r;
  logic [MAX_VERTICES-1:0] in_tree_r;
  logic [WGT_W-1:0]      cand_cost_r;
  logic [VW-1:0]         cand_v_r;
  logic [VW-1:0]         cand_par_r;
  logic                  found_r;
  logic [TOT_W-1:0]      total_r;

  logic [WGT_W-1:0]      adj_mem [Depth];
  logic [WGT_W-1:0]      adj_rd_r;
  logic [VW+WGT_W-1:0]   cost_mem [MAX_VERTICES];
  logic [VW+WGT_W-1:0]   cost_rd_r;

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [VTX_W-1:0]      out_joined_r;
  logic [VTX_W-1:0]      out_parent_r;
  logic [WGT_W-1:0]      out_weight_r;
  logic [TOT_W-1:0]      out_total_r;
  logic                  out_all_r;
  logic                  out_last_r;

  logic                  accept;
  logic                  in_range;
  logic [NW-1:0]         n_eff;
  logic                  last_j;
  logic                  last_j1;
  logic [AW-1:0]         adj_raddr;
  logic [AW-1:0]         ab_addr;
  logic [AW-1:0]         ba_addr;
  logic                  adj_we;
  logic [AW-1:0]         adj_waddr;
  logic [WGT_W-1:0]      adj_wdata;
  logic [WGT_W-1:0]      old_cost;
  logic [VW-1:0]         old_par;
  logic                  relax;
  logic [WGT_W-1:0]      new_cost;
  logic [VW-1:0]         new_par;
  logic                  better;
  logic [TOT_W-1:0]      total_nxt;

  assign busy      = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign in_range  = (int'(in_vertex_a) < MAX_VERTICES) && (int'(in_vertex_b) < MAX_VERTICES);

  // clamp the configured count into 1..MAX_VERTICES
  always_comb begin
    if (count_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(count_r) > MAX_VERTICES) begin
      n_eff = NMax;
    end else begin
      n_eff = NW'(count_r);
    end
  end

  assign last_j    = NW'(issue_j_r) == (n_r - NW'(1));
  assign last_j1   = NW'(j1_r) == (n_r - NW'(1));
  assign adj_raddr = AW'(piv_r) * Stride + AW'(issue_j_r);
  assign ab_addr   = AW'(in_vertex_a) * Stride + AW'(in_vertex_b);
  assign ba_addr   = AW'(in_vertex_b) * Stride + AW'(in_vertex_a);

  // relax one vertex against the pivot row and track the cheapest outside vertex
  assign old_cost  = cost_rd_r[WGT_W-1:0];
  assign old_par   = cost_rd_r[VW+WGT_W-1:WGT_W];
  assign relax     = init_r || (!in_tree_r[j1_r] && (adj_rd_r < old_cost));
  assign new_cost  = relax ? adj_rd_r : old_cost;
  assign new_par   = relax ? piv_r : old_par;
  assign better    = !in_tree_r[j1_r] && (new_cost < cand_cost_r);
  assign total_nxt = total_r + TOT_W'(cand_cost_r);

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = clr_addr_r;
    adj_wdata = NO_EDGE;
    case (state_r)
      S_CLEAR: begin
        adj_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && (in_command == CMD_ADD) && in_range) begin
          adj_we    = 1'b1;
          adj_waddr = ab_addr;
          adj_wdata = in_edge_weight;
        end
      end
      S_ADD2: begin
        adj_we    = 1'b1;
        adj_waddr = add_addr_r;
        adj_wdata = add_w_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd_r <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      cost_mem[j1_r] <= {new_par, new_cost};
    end
    cost_rd_r <= cost_mem[issue_j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= COUNT_RESET;
      in_tree_r   <= '0;
      total_r     <= '0;
      iss_r       <= 1'b0;
      v1_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a result leaves on the root of a run and on every join step
      out_valid_r <= (state_r == S_JOIN) ||
                     ((state_r == S_IDLE) && accept && (in_command == CMD_RUN));
      v1_r        <= (state_r == S_PASS) && iss_r;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_vertex_count;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LastAddr) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if ((in_command == CMD_ADD) && in_range) begin
              add_addr_r <= ba_addr;
              add_w_r    <= in_edge_weight;
              state_r    <= S_ADD2;
            end else if (in_command == CMD_CLEAR) begin
              clr_addr_r <= '0;
              state_r    <= S_CLEAR;
            end else if (in_command == CMD_RUN) begin
              n_r          <= n_eff;
              joined_r     <= NW'(1);
              in_tree_r    <= MAX_VERTICES'(1);
              total_r      <= '0;
              piv_r        <= '0;
              init_r       <= 1'b1;
              cand_cost_r  <= NO_EDGE;
              found_r      <= 1'b0;
              issue_j_r    <= VW'(1);
              iss_r        <= (n_eff != NW'(1));
              state_r      <= (n_eff == NW'(1)) ? S_JOIN : S_PASS;
              // root result
              out_kind_r   <= KIND_JOIN;
              out_joined_r <= '0;
              out_parent_r <= '0;
              out_weight_r <= '0;
              out_total_r  <= '0;
              out_all_r    <= 1'b0;
              out_last_r   <= 1'b0;
            end
          end
        end
        S_ADD2: begin
          state_r <= S_IDLE;
        end
        S_PASS: begin
          if (iss_r) begin
            j1_r <= issue_j_r;
            if (last_j) begin
              iss_r <= 1'b0;
            end else begin
              issue_j_r <= issue_j_r + VW'(1);
            end
          end
          if (v1_r) begin
            if (better) begin
              cand_cost_r <= new_cost;
              cand_v_r    <= j1_r;
              cand_par_r  <= new_par;
              found_r     <= 1'b1;
            end
            if (last_j1) begin
              state_r <= S_JOIN;
            end
          end
        end
        S_JOIN: begin
          if (found_r) begin
            total_r              <= total_nxt;
            in_tree_r[cand_v_r]  <= 1'b1;
            joined_r             <= joined_r + NW'(1);
            out_kind_r           <= KIND_JOIN;
            out_joined_r         <= VTX_W'(cand_v_r);
            out_parent_r         <= VTX_W'(cand_par_r);
            out_weight_r         <= cand_cost_r;
            out_total_r          <= total_nxt;
            out_all_r            <= 1'b0;
            out_last_r           <= 1'b0;
            // next pass relaxes against the vertex just joined
            piv_r        <= cand_v_r;
            init_r       <= 1'b0;
            cand_cost_r  <= NO_EDGE;
            found_r      <= 1'b0;
            issue_j_r    <= VW'(1);
            iss_r        <= 1'b1;
            state_r      <= S_PASS;
          end else begin
            out_kind_r   <= KIND_SUMMARY;
            out_joined_r <= '0;
            out_parent_r <= '0;
            out_weight_r <= '0;
            out_total_r  <= total_r;
            out_all_r    <= (joined_r == n_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_joined_vertex  = out_joined_r;
  assign out_parent_vertex  = out_parent_r;
  assign out_joining_weight = out_weight_r;
  assign out_total_weight   = out_total_r;
  assign out_all_reached    = out_all_r;
  assign out_last           = out_last_r;

endmodule

[rtl/core/pmst_checker.sv]
module pmst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [pmst_pkg::CMD_W-1:0]  in_command,
  input logic                        out_valid,
  input logic                        out_kind,
  input logic [pmst_pkg::VTX_W-1:0]  out_joined_vertex,
  input logic [pmst_pkg::TOT_W-1:0]  out_total_weight,
  input logic                        out_last
);
  import pmst_pkg::*;

  // a run reports the root right after the request is taken
  a_root_first: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_RUN)) |=>
      (out_valid && (out_kind == KIND_JOIN) && (out_joined_vertex == '0) &&
       (out_total_weight == '0)))
    else $error("root result missing after run request");

  // add and clear produce nothing
  a_quiet_load: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_command == CMD_ADD) || (in_command == CMD_CLEAR))) |=>
      !out_valid)
    else $error("result after add or clear request");

  // only the summary carries last
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind == KIND_SUMMARY))
    else $error("last flag on a non-summary result");

  // block frees up right after the summary
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> (!busy && !out_valid))
    else $error("block still busy after summary");

endmodule

bind prim_mst_adjacency_matrix pmst_checker u_pmst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_kind          (out_kind),
  .out_joined_vertex (out_joined_vertex),
  .out_total_weight  (out_total_weight),
  .out_last          (out_last)
);

[tb/prim_mst_adjacency_matrix_tb.sv]
`timescale 1ns / 100ps

module prim_mst_adjacency_matrix_tb;
  import pmst_pkg::*;

  localparam int NV           = 32;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE_WAIT  = 1100;   // covers a full matrix sweep after clear
  localparam int PHASE_BUDGET = 24;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CMD_W-1:0]  cmd;
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
    logic [WGT_W-1:0]  wgt;
    logic [CNT_W-1:0]  cnt;
    logic              typed;
    logic [TOT_W-1:0]  typed_total;
    logic              typed_all;
  } dir_row_t;

  typedef struct packed {
    logic              kind;
    logic [VTX_W-1:0]  joined;
    logic [VTX_W-1:0]  parent;
    logic [WGT_W-1:0]  join_wgt;
    logic [TOT_W-1:0]  total;
    logic              all_reached;
    logic              last;
  } tree_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [CMD_W-1:0] in_command;
  logic [VTX_W-1:0] in_vertex_a;
  logic [VTX_W-1:0] in_vertex_b;
  logic [WGT_W-1:0] in_edge_weight;
  logic cfg_valid;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_vertex_count;
  logic out_valid;
  logic out_kind;
  logic [VTX_W-1:0] out_joined_vertex;
  logic [VTX_W-1:0] out_parent_vertex;
  logic [WGT_W-1:0] out_joining_weight;
  logic [TOT_W-1:0] out_total_weight;
  logic out_all_reached;
  logic out_last;

  prim_mst_adjacency_matrix #(.MAX_VERTICES(NV)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .in_edge_weight     (in_edge_weight),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_vertex_count   (cfg_vertex_count),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_joined_vertex  (out_joined_vertex),
    .out_parent_vertex  (out_parent_vertex),
    .out_joining_weight (out_joining_weight),
    .out_total_weight   (out_total_weight),
    .out_all_reached    (out_all_reached),
    .out_last           (out_last)
  );

  // shadow copy of the graph and the vertex count register
  logic [WGT_W-1:0] edge_w [NV][NV];
  logic [CNT_W-1:0] used_count;

  tree_result_t tree_results_q [$];
  tree_result_t got_res;
  tree_result_t want_res;
  int mismatches;
  int cycles;
  int sender_idle_pct;
  int issued;

  dir_row_t dir_rows [0:22] = '{
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b1, 22'd0, 1'b0},
    '{ROW_REQ, CMD_UNUSED, 5'd31, 5'd31, 17'h1FFFF,  6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd0,  5'd0,  17'd7,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd31, 5'd0,  17'd0,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd0,  5'd1,  17'd99998,  6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd1,  5'd2,  17'd99999,  6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd2,  5'd3,  17'h1FFFF,  6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd0,  5'd2,  17'd5,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd3,  5'd0,  17'd5,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_CLEAR,  5'd0,  5'd0,  17'd0,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b1, 22'd0, 1'b0},
    '{ROW_CFG, CMD_ADD,    5'd0,  5'd0,  17'd0,      6'd1,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd0,  5'd1,  17'd3,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b1, 22'd0, 1'b1},
    '{ROW_CFG, CMD_ADD,    5'd0,  5'd0,  17'd0,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b1, 22'd0, 1'b1},
    '{ROW_CFG, CMD_ADD,    5'd0,  5'd0,  17'd0,      6'd63, 1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_CFG, CMD_ADD,    5'd0,  5'd0,  17'd0,      6'd3,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd1,  5'd2,  17'd4,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_ADD,    5'd2,  5'd0,  17'd4,      6'd0,  1'b0, 22'd0, 1'b0},
    '{ROW_REQ, CMD_RUN,    5'd0,  5'd0,  17'd0,      6'd0,  1'b0, 22'd0, 1'b0}
  };

  int phase_counts [9] = '{7, 32, 1, 63, 2, 16, 0, 31, 5};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamped_count();
    if (used_count < 1) return 1;
    if (used_count > NV) return NV;
    return int'(used_count);
  endfunction

  // grow the tree from vertex 0 and queue one result per joined vertex, then a summary
  function automatic void predict_tree_build();
    int n;
    int joined;
    int best;
    int pick;
    bit found;
    logic [TOT_W-1:0] total;
    logic [WGT_W-1:0] reach_cost [NV];
    logic [VTX_W-1:0] reach_parent [NV];
    bit in_span [NV];
    n = clamped_count();
    joined = 1;
    total = '0;
    for (int j = 0; j < NV; j++) in_span[j] = 1'b0;
    in_span[0] = 1'b1;
    for (int j = 1; j < n; j++) begin
      reach_cost[j] = edge_w[0][j];
      reach_parent[j] = '0;
    end
    tree_results_q.push_back('{KIND_JOIN, 5'd0, 5'd0, 17'd0, 22'd0, 1'b0, 1'b0});
    forever begin
      best = int'(NO_EDGE);
      pick = 0;
      found = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (!in_span[j] && int'(reach_cost[j]) < best) begin
          best = int'(reach_cost[j]);
          pick = j;
          found = 1'b1;
        end
      end
      if (!found) break;
      total = total + TOT_W'(best);
      in_span[pick] = 1'b1;
      joined++;
      tree_results_q.push_back('{KIND_JOIN, VTX_W'(pick), reach_parent[pick],
                                 WGT_W'(best), total, 1'b0, 1'b0});
      for (int j = 1; j < n; j++) begin
        if (!in_span[j] && edge_w[pick][j] < reach_cost[j]) begin
          reach_cost[j] = edge_w[pick][j];
          reach_parent[j] = VTX_W'(pick);
        end
      end
    end
    tree_results_q.push_back('{KIND_SUMMARY, 5'd0, 5'd0, 17'd0, total,
                               (joined == n), 1'b1});
  endfunction

  function automatic void predict_request(input logic [CMD_W-1:0] cmd,
                                          input logic [VTX_W-1:0] va,
                                          input logic [VTX_W-1:0] vb,
                                          input logic [WGT_W-1:0] wgt);
    case (cmd)
      CMD_ADD: begin
        edge_w[va][vb] = wgt;
        edge_w[vb][va] = wgt;
      end
      CMD_CLEAR: begin
        for (int r = 0; r < NV; r++)
          for (int c = 0; c < NV; c++) edge_w[r][c] = NO_EDGE;
      end
      CMD_RUN: predict_tree_build();
      default: ;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [VTX_W-1:0] va,
                              input logic [VTX_W-1:0] vb,
                              input logic [WGT_W-1:0] wgt,
                              input bit typed,
                              input logic [TOT_W-1:0] typed_total,
                              input logic typed_all);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_command = cmd;
    in_vertex_a = va;
    in_vertex_b = vb;
    in_edge_weight = wgt;
    do @(posedge clk); while (busy);
    if (typed) begin
      tree_results_q.push_back('{KIND_JOIN, 5'd0, 5'd0, 17'd0, 22'd0, 1'b0, 1'b0});
      tree_results_q.push_back('{KIND_SUMMARY, 5'd0, 5'd0, 17'd0, typed_total,
                                 typed_all, 1'b1});
    end else begin
      predict_request(cmd, va, vb, wgt);
    end
    issued++;
    @(negedge clk);
  endtask

  // only touch the count register once the block has drained
  task automatic write_vertex_count(input logic [CNT_W-1:0] value);
    start = 1'b0;
    while (tree_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_vertex_count = value;
    do @(posedge clk); while (!cfg_ready);
    used_count = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [WGT_W-1:0] pick_weight();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return WGT_W'($urandom_range(131071, 99999));
    if (roll < 30) return WGT_W'($urandom_range(99998));
    return WGT_W'($urandom_range(40));
  endfunction

  // mostly connected graphs, usually built from scratch after a clear, with some noise requests
  task automatic random_phase(input int budget);
    int goal;
    int n;
    int nb;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    goal = issued + budget;
    n = clamped_count();
    while (issued < goal) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) != 0)
          send_request(CMD_CLEAR, VTX_W'($urandom), VTX_W'($urandom),
                       WGT_W'($urandom), 1'b0, '0, 1'b0);
        for (int v = 1; v < n; v++) begin
          // drop a tree edge now and then so some vertices stay unreachable
          if ($urandom_range(99) < 5) continue;
          va = VTX_W'(v);
          vb = VTX_W'($urandom_range(v - 1, 0));
          if ($urandom_range(1) != 0)
            send_request(CMD_ADD, vb, va, pick_weight(), 1'b0, '0, 1'b0);
          else
            send_request(CMD_ADD, va, vb, pick_weight(), 1'b0, '0, 1'b0);
        end
        nb = $urandom_range(n / 2);
        for (int k = 0; k < nb; k++)
          send_request(CMD_ADD, VTX_W'($urandom_range(n - 1)),
                       VTX_W'($urandom_range(n - 1)), pick_weight(), 1'b0, '0, 1'b0);
        send_request(CMD_RUN, VTX_W'($urandom), VTX_W'($urandom),
                     WGT_W'($urandom), 1'b0, '0, 1'b0);
      end else begin
        send_request(CMD_W'($urandom_range(3)), VTX_W'($urandom), VTX_W'($urandom),
                     WGT_W'($urandom), 1'b0, '0, 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_res = '{out_kind, out_joined_vertex, out_parent_vertex, out_joining_weight,
                  out_total_weight, out_all_reached, out_last};
      if (tree_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d v=%0d p=%0d w=%0d tot=%0d all=%0d last=%0d",
                   got_res.kind, got_res.joined, got_res.parent, got_res.join_wgt,
                   got_res.total, got_res.all_reached, got_res.last);
      end else begin
        want_res = tree_results_q.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: kind=%0d v=%0d p=%0d w=%0d tot=%0d all=%0d last=%0d",
                     want_res.kind, want_res.joined, want_res.parent, want_res.join_wgt,
                     want_res.total, want_res.all_reached, want_res.last);
            $display("         got: kind=%0d v=%0d p=%0d w=%0d tot=%0d all=%0d last=%0d",
                     got_res.kind, got_res.joined, got_res.parent, got_res.join_wgt,
                     got_res.total, got_res.all_reached, got_res.last);
          end
        end
      end
    end
  end

  initial begin
    issued = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ADD;
    in_vertex_a = '0;
    in_vertex_b = '0;
    in_edge_weight = '0;
    cfg_valid = 1'b0;
    cfg_vertex_count = '0;
    used_count = COUNT_RESET;
    for (int r = 0; r < NV; r++)
      for (int c = 0; c < NV; c++) edge_w[r][c] = NO_EDGE;
    sender_idle_pct = 27;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_vertex_count(dir_rows[i].cnt);
      else
        send_request(dir_rows[i].cmd, dir_rows[i].va, dir_rows[i].vb, dir_rows[i].wgt,
                     dir_rows[i].typed, dir_rows[i].typed_total, dir_rows[i].typed_all);
    end

    phase_counts[8] = $urandom_range(63);
    for (int p = 0; p < 9; p++) begin
      sender_idle_pct = (p < 3) ? 27 : (p < 6) ? 55 : 0;
      write_vertex_count(CNT_W'(phase_counts[p]));
      random_phase(PHASE_BUDGET);
    end

    start = 1'b0;
    while (tree_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/core/pmst_pkg.sv
rtl/core/prim_mst_adjacency_matrix.sv
rtl/core/pmst_checker.sv
tb/prim_mst_adjacency_matrix_tb.sv
